// ===== rtl/itf_pkg.sv =====
// ----------------------------------------------------------------------------
// itf_pkg
// Shared constants, types and helpers of the integer text formatter.
// ----------------------------------------------------------------------------
package itf_pkg;

   localparam int MAX_FIELD    = 60;
   localparam int RESULT_LIMIT = 62;
   localparam int MAG_W        = 64;
   localparam int NUM_DIGITS   = 22;               // octal needs the most digits
   localparam int DIG_BITS     = NUM_DIGITS * 4;
   localparam int OCT_BITS     = NUM_DIGITS * 3;
   localparam int DCNT_W       = 5;                // holds NUM_DIGITS
   localparam int CNT_W        = 7;                // holds any character count
   localparam int FIELD_W      = 6;
   localparam int BIT_CNT_W    = 6;                // indexes MAG_W bits

   localparam logic [1:0] RADIX_DEC = 2'd0;
   localparam logic [1:0] RADIX_OCT = 2'd1;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_A_UP  = 8'h41;
   localparam logic [7:0] CHAR_A_LO  = 8'h61;
   localparam logic [7:0] CHAR_X_UP  = 8'h58;
   localparam logic [7:0] CHAR_X_LO  = 8'h78;

   typedef struct packed {
      logic              done;
      logic [DCNT_W-1:0] count;
   } dig_status_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
      logic [7:0] d8;
      d8 = 8'(d);
      if (d < 4'd10) begin
         return CHAR_ZERO + d8;
      end
      return (up ? CHAR_A_UP : CHAR_A_LO) + d8 - 8'd10;
   endfunction

endpackage

// ===== rtl/integer_text_formatter_core.sv =====
// ----------------------------------------------------------------------------
// integer_text_formatter_core
// Renders one printf style integer conversion as a stream of characters.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the last character has been sent. Characters come out one per cycle
// on rsp_text_char with rsp_valid high for exactly one cycle each, and the
// receiver must take them as they come. A decimal request first goes through
// bit-serial binary to bcd conversion, octal and hex load their digits at
// once; then leading zero digits are stripped, keeping at least one digit,
// the ST_CALC state sizes the fields, and the characters follow (at least
// one, at most 62). A conversion with no text gives a single result with
// rsp_empty_text high.
// ----------------------------------------------------------------------------
module integer_text_formatter_core import itf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [MAG_W-1:0]   req_magnitude,
   input  logic               req_negative,
   input  logic               req_signed_conv,
   input  logic [1:0]         req_radix_code,
   input  logic               req_upper_case,
   input  logic               req_left_justify,
   input  logic               req_force_plus,
   input  logic               req_space_sign,
   input  logic               req_zero_pad,
   input  logic               req_alternate_form,
   input  logic [FIELD_W-1:0] req_field_width,
   input  logic signed [6:0]  req_precision,
   output logic               rsp_valid,
   output logic [7:0]         rsp_text_char,
   output logic               rsp_last_char,
   output logic               rsp_empty_text
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_CALC = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type          state_ff, state_in;

   // request fields held for the whole conversion
   logic               neg_ff, neg_in;
   logic               sgnd_ff, sgnd_in;
   logic [1:0]         radix_ff, radix_in;
   logic               up_ff, up_in;
   logic               lj_ff, lj_in;
   logic               fp_ff, fp_in;
   logic               fsp_ff, fsp_in;
   logic               zp_ff, zp_in;
   logic               fh_ff, fh_in;
   logic               mag_zero_ff, mag_zero_in;
   logic [FIELD_W-1:0] width_ff, width_in;
   logic               prec_given_ff, prec_given_in;
   logic [FIELD_W-1:0] prec_ff, prec_in;

   // characters left in each part of the text
   logic [CNT_W-1:0]   lead_ff, lead_in;
   logic [1:0]         pfx_ff, pfx_in;
   logic [CNT_W-1:0]   zpad_ff, zpad_in;
   logic [CNT_W-1:0]   pzero_ff, pzero_in;
   logic [CNT_W-1:0]   dig_cnt_ff, dig_cnt_in;
   logic [CNT_W-1:0]   trail_ff, trail_in;
   logic [7:0]         pfx_a_ff, pfx_a_in;
   logic [7:0]         pfx_b_ff, pfx_b_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]   sent_ff, sent_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_empty_ff, rsp_empty_in;

   logic               accept;
   logic               du_start;
   logic               du_shift;
   dig_status_type     du_status;
   logic [3:0]         du_top;

   // sizing terms
   logic               base8, base16;
   logic               has_sc;
   logic [7:0]         sc;
   logic               zero_case;
   logic               dozp;
   logic [CNT_W-1:0]   dl, pp, pl, content, pad, total, wid, prc;
   logic [FIELD_W-1:0] sat_width, sat_prec;

   itf_digit_unit u_digits (
      .clock      (clock),
      .reset      (reset),
      .start      (du_start),
      .magnitude  (req_magnitude),
      .radix_code (req_radix_code),
      .shift_en   (du_shift),
      .status     (du_status),
      .top_digit  (du_top)
   );

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign du_start = accept;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_text_char  = rsp_char_ff;
   assign rsp_last_char  = rsp_last_ff;
   assign rsp_empty_text = rsp_empty_ff;

   always_comb begin
      sat_width = (req_field_width > FIELD_W'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD)
                                                          : req_field_width;
      sat_prec  = (req_precision[5:0] > FIELD_W'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD)
                                                             : req_precision[5:0];
   end

   always_comb begin
      base8  = (radix_ff == RADIX_OCT);
      base16 = (radix_ff != RADIX_DEC) && !base8;
      has_sc = sgnd_ff && (neg_ff || fp_ff || fsp_ff);
      sc     = neg_ff ? CHAR_MINUS : (fp_ff ? CHAR_PLUS : CHAR_SPACE);
      // zero value with precision zero prints no digits, unless alternate form octal
      zero_case = prec_given_ff && prec_ff == '0 && mag_zero_ff && !(fh_ff && base8);
      dozp   = zp_ff && !prec_given_ff && !lj_ff;
      wid    = CNT_W'(width_ff);
      prc    = CNT_W'(prec_ff);
      dl     = zero_case ? '0 : CNT_W'(du_status.count);
      pp     = (prec_given_ff && dl < prc) ? prc - dl : '0;
      pl       = '0;
      pfx_a_in = CHAR_ZERO;
      pfx_b_in = CHAR_ZERO;
      if (sgnd_ff) begin
         pl       = has_sc ? CNT_W'(1) : '0;
         pfx_b_in = sc;
      end else if (fh_ff && !mag_zero_ff) begin
         if (base8 && pp == '0) begin
            pl = CNT_W'(1);
         end else if (base16) begin
            pl       = CNT_W'(2);
            pfx_b_in = up_ff ? CHAR_X_UP : CHAR_X_LO;
         end
      end
      content = pl + pp + dl;
      pad     = (wid > content) ? wid - content : '0;
      total   = content + pad;
   end

   always_comb begin
      state_in      = state_ff;
      neg_in        = neg_ff;
      sgnd_in       = sgnd_ff;
      radix_in      = radix_ff;
      up_in         = up_ff;
      lj_in         = lj_ff;
      fp_in         = fp_ff;
      fsp_in        = fsp_ff;
      zp_in         = zp_ff;
      fh_in         = fh_ff;
      mag_zero_in   = mag_zero_ff;
      width_in      = width_ff;
      prec_given_in = prec_given_ff;
      prec_in       = prec_ff;
      lead_in       = lead_ff;
      pfx_in        = pfx_ff;
      zpad_in       = zpad_ff;
      pzero_in      = pzero_ff;
      dig_cnt_in    = dig_cnt_ff;
      trail_in      = trail_ff;
      total_in      = total_ff;
      sent_in       = sent_ff;
      rsp_valid_in  = 1'b0;
      rsp_char_in   = rsp_char_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      du_shift      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in        = req_negative;
               sgnd_in       = req_signed_conv;
               radix_in      = req_radix_code;
               up_in         = req_upper_case;
               lj_in         = req_left_justify;
               fp_in         = req_force_plus;
               fsp_in        = req_space_sign;
               zp_in         = req_zero_pad;
               fh_in         = req_alternate_form;
               mag_zero_in   = (req_magnitude == '0);
               width_in      = sat_width;
               prec_given_in = !req_precision[6];
               prec_in       = req_precision[6] ? '0 : sat_prec;
               state_in      = ST_CONV;
            end
         end
         ST_CONV: begin
            if (du_status.done) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            lead_in    = (!lj_ff && !dozp) ? pad : '0;
            zpad_in    = (!lj_ff && dozp) ? pad : '0;
            trail_in   = lj_ff ? pad : '0;
            pfx_in     = pl[1:0];
            pzero_in   = pp;
            dig_cnt_in = dl;
            total_in   = (total > CNT_W'(RESULT_LIMIT)) ? CNT_W'(RESULT_LIMIT) : total;
            sent_in    = '0;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_empty_in = 1'b0;
            rsp_last_in  = (sent_ff + 1'b1 == total_ff);
            sent_in      = sent_ff + 1'b1;
            if (total_ff == '0) begin
               rsp_char_in  = CHAR_NUL;
               rsp_last_in  = 1'b1;
               rsp_empty_in = 1'b1;
            end else if (lead_ff != '0) begin
               rsp_char_in = CHAR_SPACE;
               lead_in     = lead_ff - 1'b1;
            end else if (pfx_ff != '0) begin
               rsp_char_in = (pfx_ff == 2'd2) ? pfx_a_ff : pfx_b_ff;
               pfx_in      = pfx_ff - 1'b1;
            end else if (zpad_ff != '0) begin
               rsp_char_in = CHAR_ZERO;
               zpad_in     = zpad_ff - 1'b1;
            end else if (pzero_ff != '0) begin
               rsp_char_in = CHAR_ZERO;
               pzero_in    = pzero_ff - 1'b1;
            end else if (dig_cnt_ff != '0) begin
               rsp_char_in = digit_char(du_top, up_ff);
               dig_cnt_in  = dig_cnt_ff - 1'b1;
               du_shift    = 1'b1;
            end else begin
               rsp_char_in = CHAR_SPACE;
               trail_in    = trail_ff - 1'b1;
            end
            if (rsp_last_in) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff        <= neg_in;
      sgnd_ff       <= sgnd_in;
      radix_ff      <= radix_in;
      up_ff         <= up_in;
      lj_ff         <= lj_in;
      fp_ff         <= fp_in;
      fsp_ff        <= fsp_in;
      zp_ff         <= zp_in;
      fh_ff         <= fh_in;
      mag_zero_ff   <= mag_zero_in;
      width_ff      <= width_in;
      prec_given_ff <= prec_given_in;
      prec_ff       <= prec_in;
      lead_ff       <= lead_in;
      pfx_ff        <= pfx_in;
      zpad_ff       <= zpad_in;
      pzero_ff      <= pzero_in;
      dig_cnt_ff    <= dig_cnt_in;
      trail_ff      <= trail_in;
      pfx_a_ff      <= (state_ff == ST_CALC) ? pfx_a_in : pfx_a_ff;
      pfx_b_ff      <= (state_ff == ST_CALC) ? pfx_b_in : pfx_b_ff;
      total_ff      <= total_in;
      sent_ff       <= sent_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

endmodule

// ===== rtl/itf_digit_unit.sv =====
// ----------------------------------------------------------------------------
// itf_digit_unit
// Splits the magnitude into digits, most significant first. Decimal goes
// through a bit-serial double dabble, then leading zeros are shifted out one
// digit a cycle. The digits then leave one at a time from the top.
// ----------------------------------------------------------------------------
module itf_digit_unit import itf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MAG_W-1:0] magnitude,
   input  logic [1:0]       radix_code,
   input  logic             shift_en,
   output dig_status_type   status,
   output logic [3:0]       top_digit
);

   typedef enum logic [3:0] {
      DU_IDLE = 4'b0001,
      DU_BCD  = 4'b0010,
      DU_NORM = 4'b0100,
      DU_DONE = 4'b1000
   } du_state_type;

   du_state_type           state_ff, state_in;
   logic [DIG_BITS-1:0]    dig_ff, dig_in;
   logic [MAG_W-1:0]       src_ff, src_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DCNT_W-1:0]      lz_ff, lz_in;

   logic [DIG_BITS-1:0]    adj;
   logic [DIG_BITS-1:0]    oct_load;
   logic [DIG_BITS-1:0]    hex_load;
   logic [OCT_BITS-1:0]    mag_ext;
   logic [DIG_BITS-1:0]    shl4;

   always_comb begin
      mag_ext  = OCT_BITS'(magnitude);
      hex_load = DIG_BITS'(magnitude);
      for (int i = 0; i < NUM_DIGITS; i++) begin
         oct_load[i*4 +: 4] = {1'b0, mag_ext[i*3 +: 3]};
         // add three to every bcd digit of five or more before the shift
         adj[i*4 +: 4] = (dig_ff[i*4 +: 4] >= 4'd5) ? dig_ff[i*4 +: 4] + 4'd3
                                                    : dig_ff[i*4 +: 4];
      end
      shl4 = {dig_ff[DIG_BITS-5:0], 4'b0000};
   end

   assign top_digit    = dig_ff[DIG_BITS-1 -: 4];
   assign status.done  = (state_ff == DU_DONE);
   assign status.count = DCNT_W'(NUM_DIGITS) - lz_ff;

   always_comb begin
      state_in   = state_ff;
      dig_in     = dig_ff;
      src_in     = src_ff;
      bit_cnt_in = bit_cnt_ff;
      lz_in      = lz_ff;
      case (state_ff)
         DU_IDLE, DU_DONE: begin
            if (state_ff == DU_DONE && shift_en) begin
               dig_in = shl4;
            end
            if (start) begin
               lz_in = '0;
               if (radix_code == RADIX_DEC) begin
                  dig_in     = '0;
                  src_in     = magnitude;
                  bit_cnt_in = BIT_CNT_W'(MAG_W - 1);
                  state_in   = DU_BCD;
               end else begin
                  dig_in   = (radix_code == RADIX_OCT) ? oct_load : hex_load;
                  state_in = DU_NORM;
               end
            end
         end
         DU_BCD: begin
            dig_in     = {adj[DIG_BITS-2:0], src_ff[MAG_W-1]};
            src_in     = {src_ff[MAG_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - 1'b1;
            if (bit_cnt_ff == '0) begin
               state_in = DU_NORM;
            end
         end
         DU_NORM: begin
            // keep at least one digit, a zero value prints one zero
            if (top_digit == 4'd0 && lz_ff < DCNT_W'(NUM_DIGITS - 1)) begin
               dig_in = shl4;
               lz_in  = lz_ff + 1'b1;
            end else begin
               state_in = DU_DONE;
            end
         end
         default: begin
            state_in = DU_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DU_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dig_ff     <= dig_in;
      src_ff     <= src_in;
      bit_cnt_ff <= bit_cnt_in;
      lz_ff      <= lz_in;
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the integer text formatter against a behavioral printf renderer.
// Directed requests cover empty text, extremes, signs, padding, prefixes and
// saturation; random requests follow in phases with and without start gaps.
// Every character strobe is compared in order with the predicted text.
// ----------------------------------------------------------------------------
module tb import itf_pkg::*; ();

   localparam logic [1:0] RADIX_HEX   = 2'd2;
   localparam logic [1:0] RADIX_SPARE = 2'd3;   // unused code, behaves as hex

   localparam int PREC_ABSENT = -1;

   // flag masks for building directed requests
   localparam logic [5:0] F_UPPER = 6'b000001;
   localparam logic [5:0] F_LEFT  = 6'b000010;
   localparam logic [5:0] F_PLUS  = 6'b000100;
   localparam logic [5:0] F_SPACE = 6'b001000;
   localparam logic [5:0] F_ZERO  = 6'b010000;
   localparam logic [5:0] F_ALT   = 6'b100000;

   typedef struct {
      logic [MAG_W-1:0]   magnitude;
      logic               negative;
      logic               signed_conv;
      logic [1:0]         radix_code;
      logic               upper_case;
      logic               left_justify;
      logic               force_plus;
      logic               space_sign;
      logic               zero_pad;
      logic               alternate_form;
      logic [FIELD_W-1:0] field_width;
      logic signed [6:0]  precision;
   } conversion_type;

   typedef struct {
      logic [7:0] text_char;
      logic       last_char;
      logic       empty_text;
   } text_result_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [MAG_W-1:0]   req_magnitude;
   logic               req_negative;
   logic               req_signed_conv;
   logic [1:0]         req_radix_code;
   logic               req_upper_case;
   logic               req_left_justify;
   logic               req_force_plus;
   logic               req_space_sign;
   logic               req_zero_pad;
   logic               req_alternate_form;
   logic [FIELD_W-1:0] req_field_width;
   logic signed [6:0]  req_precision;
   logic               rsp_valid;
   logic [7:0]         rsp_text_char;
   logic               rsp_last_char;
   logic               rsp_empty_text;

   text_result_type expected_chars[$];
   int              mismatches = 0;
   int              idle_pct   = 0;

   integer_text_formatter_core dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_magnitude      (req_magnitude),
      .req_negative       (req_negative),
      .req_signed_conv    (req_signed_conv),
      .req_radix_code     (req_radix_code),
      .req_upper_case     (req_upper_case),
      .req_left_justify   (req_left_justify),
      .req_force_plus     (req_force_plus),
      .req_space_sign     (req_space_sign),
      .req_zero_pad       (req_zero_pad),
      .req_alternate_form (req_alternate_form),
      .req_field_width    (req_field_width),
      .req_precision      (req_precision),
      .rsp_valid          (rsp_valid),
      .rsp_text_char      (rsp_text_char),
      .rsp_last_char      (rsp_last_char),
      .rsp_empty_text     (rsp_empty_text)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // expected character stream of one conversion, appended to expected_chars
   function automatic void render_text(input conversion_type c);
      logic [7:0]       line[$];
      logic [7:0]       digs[$];
      logic [7:0]       pfx[$];
      logic [MAG_W-1:0] v;
      logic [MAG_W-1:0] base;
      string            digit_set;
      int               w, prec, pp, content, pad, n;
      bit               prec_given, dozp;
      logic [7:0]       sc;
      text_result_type  r;
      base = (c.radix_code == RADIX_DEC) ? 64'd10 : (c.radix_code == RADIX_OCT) ? 64'd8 : 64'd16;
      digit_set = c.upper_case ? "0123456789ABCDEF" : "0123456789abcdef";
      w = (c.field_width > MAX_FIELD) ? MAX_FIELD : int'(c.field_width);
      prec_given = !c.precision[6];
      prec = 0;
      if (prec_given) begin
         prec = (int'(c.precision) > MAX_FIELD) ? MAX_FIELD : int'(c.precision);
      end
      sc = CHAR_NUL;
      if (c.signed_conv) begin
         sc = c.negative ? CHAR_MINUS : c.force_plus ? CHAR_PLUS :
              c.space_sign ? CHAR_SPACE : CHAR_NUL;
      end
      if (prec_given && prec == 0 && c.magnitude == 0 && !(c.alternate_form && base == 8)) begin
         content = (sc != CHAR_NUL) ? 1 : 0;
         pad = (w > content) ? w - content : 0;
         if (!c.left_justify) repeat (pad) line.push_back(CHAR_SPACE);
         if (sc != CHAR_NUL) line.push_back(sc);
         if (c.left_justify) repeat (pad) line.push_back(CHAR_SPACE);
      end else begin
         dozp = c.zero_pad && !prec_given && !c.left_justify;
         v = c.magnitude;
         do begin
            digs.push_front(digit_set[int'(v % base)]);
            v = v / base;
         end while (v != 0);
         pp = (prec_given && digs.size() < prec) ? prec - digs.size() : 0;
         if (c.signed_conv) begin
            if (sc != CHAR_NUL) pfx.push_back(sc);
         end else if (c.alternate_form && c.magnitude != 0) begin
            if (base == 8 && pp == 0) begin
               pfx.push_back(CHAR_ZERO);
            end else if (base == 16) begin
               pfx.push_back(CHAR_ZERO);
               pfx.push_back(c.upper_case ? CHAR_X_UP : CHAR_X_LO);
            end
         end
         content = pfx.size() + pp + digs.size();
         pad = (w > content) ? w - content : 0;
         if (!c.left_justify && !dozp) repeat (pad) line.push_back(CHAR_SPACE);
         foreach (pfx[i]) line.push_back(pfx[i]);
         if (!c.left_justify && dozp) repeat (pad) line.push_back(CHAR_ZERO);
         repeat (pp) line.push_back(CHAR_ZERO);
         foreach (digs[i]) line.push_back(digs[i]);
         if (c.left_justify) repeat (pad) line.push_back(CHAR_SPACE);
      end
      if (line.size() == 0) begin
         r.text_char  = CHAR_NUL;
         r.last_char  = 1'b1;
         r.empty_text = 1'b1;
         expected_chars.push_back(r);
      end else begin
         n = (line.size() > RESULT_LIMIT) ? RESULT_LIMIT : line.size();
         for (int i = 0; i < n; i++) begin
            r.text_char  = line[i];
            r.last_char  = (i == n - 1);
            r.empty_text = 1'b0;
            expected_chars.push_back(r);
         end
      end
   endfunction

   function automatic conversion_type conv(input logic [MAG_W-1:0] mag, input logic sgnd,
                                           input logic neg, input logic [1:0] radix,
                                           input logic [5:0] flags, input int width,
                                           input int prec);
      conversion_type c;
      c.magnitude      = mag;
      c.signed_conv    = sgnd;
      c.negative       = neg;
      c.radix_code     = radix;
      c.upper_case     = |(flags & F_UPPER);
      c.left_justify   = |(flags & F_LEFT);
      c.force_plus     = |(flags & F_PLUS);
      c.space_sign     = |(flags & F_SPACE);
      c.zero_pad       = |(flags & F_ZERO);
      c.alternate_form = |(flags & F_ALT);
      c.field_width    = FIELD_W'(width);
      c.precision      = 7'(prec);
      return c;
   endfunction

   // drives one request and waits until it is taken; start stays high unless a gap follows
   task automatic send_request(input conversion_type c);
      int gap;
      @(negedge clock);
      req_magnitude      <= c.magnitude;
      req_negative       <= c.negative;
      req_signed_conv    <= c.signed_conv;
      req_radix_code     <= c.radix_code;
      req_upper_case     <= c.upper_case;
      req_left_justify   <= c.left_justify;
      req_force_plus     <= c.force_plus;
      req_space_sign     <= c.space_sign;
      req_zero_pad       <= c.zero_pad;
      req_alternate_form <= c.alternate_form;
      req_field_width    <= c.field_width;
      req_precision      <= c.precision;
      start              <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      render_text(c);
      if ($urandom_range(99) < idle_pct) begin
         gap = ($urandom_range(9) < 7) ? $urandom_range(1, 6) : $urandom_range(1, 160);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic stop_requests();
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic test_empty_text();
      send_request(conv(64'd0, 1'b1, 1'b0, RADIX_DEC, 6'b0, 0, 0));
      send_request(conv(64'd0, 1'b0, 1'b0, RADIX_HEX, F_ALT, 0, 0));
      send_request(conv(64'd0, 1'b1, 1'b0, RADIX_DEC, F_PLUS, 5, 0));
      send_request(conv(64'd0, 1'b1, 1'b0, RADIX_DEC, F_SPACE | F_LEFT, 3, 0));
      send_request(conv(64'd0, 1'b0, 1'b0, RADIX_OCT, F_ALT, 4, 0));
   endtask

   task automatic test_extremes();
      send_request(conv('1, 1'b0, 1'b0, RADIX_DEC, 6'b0, 0, PREC_ABSENT));
      send_request(conv('1, 1'b0, 1'b0, RADIX_OCT, F_ALT, 0, PREC_ABSENT));
      send_request(conv('1, 1'b0, 1'b0, RADIX_HEX, F_ALT | F_UPPER, 0, PREC_ABSENT));
      send_request(conv('1, 1'b0, 1'b0, RADIX_HEX, 6'b0, 0, PREC_ABSENT));
      send_request(conv(64'h8000_0000_0000_0000, 1'b1, 1'b1, RADIX_DEC, 6'b0, 0, PREC_ABSENT));
      send_request(conv(64'd0, 1'b0, 1'b0, RADIX_DEC, 6'b0, 0, PREC_ABSENT));
   endtask

   task automatic test_signs();
      send_request(conv(64'd511, 1'b1, 1'b1, RADIX_OCT, F_ALT | F_ZERO, 10, PREC_ABSENT));
      // sign flags have no effect on unsigned conversions
      send_request(conv(64'hbeef, 1'b0, 1'b1, RADIX_HEX, F_PLUS | F_SPACE, 0, PREC_ABSENT));
      send_request(conv(64'd42, 1'b1, 1'b0, RADIX_DEC, F_PLUS | F_SPACE, 0, PREC_ABSENT));
      send_request(conv(64'd42, 1'b1, 1'b0, RADIX_DEC, F_SPACE, 0, PREC_ABSENT));
      send_request(conv(64'hcafe, 1'b1, 1'b0, RADIX_HEX, F_ALT | F_PLUS, 8, PREC_ABSENT));
   endtask

   task automatic test_padding();
      send_request(conv(64'd1234, 1'b1, 1'b1, RADIX_DEC, F_ZERO, 20, PREC_ABSENT));
      send_request(conv(64'd1234, 1'b1, 1'b1, RADIX_DEC, F_ZERO, 20, 6));
      send_request(conv(64'd1234, 1'b1, 1'b0, RADIX_DEC, F_ZERO | F_LEFT | F_PLUS, 12,
                        PREC_ABSENT));
      send_request(conv(64'hab, 1'b0, 1'b0, RADIX_HEX, F_ALT | F_ZERO, 12, PREC_ABSENT));
      // precision already supplies the leading octal zero
      send_request(conv(64'd8, 1'b0, 1'b0, RADIX_OCT, F_ALT, 0, 5));
   endtask

   task automatic test_saturation();
      send_request(conv(64'd7, 1'b1, 1'b1, RADIX_DEC, 6'b0, 63, PREC_ABSENT));
      send_request(conv(64'd7, 1'b1, 1'b1, RADIX_DEC, 6'b0, 0, 63));
      send_request(conv(64'd0, 1'b0, 1'b0, RADIX_DEC, F_ZERO, 9, -64));
      send_request(conv(64'd99, 1'b1, 1'b0, RADIX_DEC, F_ZERO, 9, -5));
      send_request(conv(64'h1234_abcd, 1'b0, 1'b0, RADIX_SPARE, F_UPPER | F_ALT | F_LEFT, 63, 63));
   endtask

   task automatic test_random(input int count, input int pct);
      conversion_type c;
      idle_pct = pct;
      repeat (count) begin
         case ($urandom_range(5))
            0: c.magnitude = '0;
            1: c.magnitude = 64'($urandom_range(0, 20));
            2: c.magnitude = {$urandom, $urandom};
            3: c.magnitude = {$urandom, $urandom} >> $urandom_range(63);
            4: c.magnitude = '1 - 64'($urandom_range(3));
            default: c.magnitude = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
         endcase
         c.negative       = 1'($urandom_range(1));
         c.signed_conv    = 1'($urandom_range(1));
         c.radix_code     = 2'($urandom_range(3));
         c.upper_case     = 1'($urandom_range(1));
         c.left_justify   = 1'($urandom_range(1));
         c.force_plus     = 1'($urandom_range(1));
         c.space_sign     = 1'($urandom_range(1));
         c.zero_pad       = 1'($urandom_range(1));
         c.alternate_form = 1'($urandom_range(1));
         c.field_width    = ($urandom_range(3) == 0) ? FIELD_W'($urandom)
                                                     : FIELD_W'($urandom_range(0, 20));
         case ($urandom_range(3))
            0: c.precision = 7'(PREC_ABSENT);
            1: c.precision = 7'($urandom);
            default: c.precision = 7'($urandom_range(0, 20));
         endcase
         send_request(c);
      end
      stop_requests();
   endtask

   // every strobe must match the oldest predicted character
   always @(posedge clock) begin
      text_result_type e;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: text_char expected none got %h", $time, rsp_text_char);
            mismatches++;
         end else begin
            e = expected_chars.pop_front();
            if (rsp_text_char !== e.text_char) begin
               $display("%0t: text_char expected %h got %h", $time, e.text_char, rsp_text_char);
               mismatches++;
            end
            if (rsp_last_char !== e.last_char) begin
               $display("%0t: last_char expected %b got %b", $time, e.last_char, rsp_last_char);
               mismatches++;
            end
            if (rsp_empty_text !== e.empty_text) begin
               $display("%0t: empty_text expected %b got %b", $time, e.empty_text,
                        rsp_empty_text);
               mismatches++;
            end
         end
      end
   end

   initial begin
      reset              = 1'b1;
      start              = 1'b0;
      req_magnitude      = '0;
      req_negative       = 1'b0;
      req_signed_conv    = 1'b0;
      req_radix_code     = RADIX_DEC;
      req_upper_case     = 1'b0;
      req_left_justify   = 1'b0;
      req_force_plus     = 1'b0;
      req_space_sign     = 1'b0;
      req_zero_pad       = 1'b0;
      req_alternate_form = 1'b0;
      req_field_width    = '0;
      req_precision      = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_empty_text();
      test_extremes();
      test_signs();
      test_padding();
      test_saturation();
      stop_requests();
      test_random(140, 0);
      test_random(140, 68);
      test_random(130, 32);

      while (expected_chars.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #15_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
